/* rtl/wpsl_pkg.sv */
// ----------------------------------------------------------------------------
// wpsl_pkg
// Shared types and constants for the wheel period speed logger.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsl_pkg;

  localparam int CFG_W      = 16;
  localparam int CNT_W      = 32;
  localparam int DVD_W      = 25;
  localparam int STEP_W     = $clog2(DVD_W);
  localparam int CIRC_SCALE = 360;
  localparam int DEC_BASE   = 100;

  localparam logic [0:0] REG_CIRC    = 1'b0;
  localparam logic [0:0] REG_LOCKOUT = 1'b1;

  // one quotient bit per transaction, MSB first
  typedef struct packed {
    logic valid;
    logic q;
    logic last;
  } qstream_t;

endpackage

`default_nettype wire

/* rtl/wpsl_if.sv */
// ----------------------------------------------------------------------------
// wpsl_if
// Valid/ready channels for sensor ticks and speed records.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpsl_in_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink   (input valid, input sensor_level, output ready);
endinterface

interface wpsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] speed_whole;
  logic [6:0] speed_hundredths;
  logic [9:0] store_address;

  modport source (output valid, output speed_whole, output speed_hundredths,
                  output store_address, input ready);
  modport sink   (input valid, input speed_whole, input speed_hundredths,
                  input store_address, output ready);
endinterface

`default_nettype wire

/* rtl/wheel_period_speed_logger.sv */
// ----------------------------------------------------------------------------
// wheel_period_speed_logger
// Hall sensor speedometer: counts ms ticks, divides circumference*360 by
// the period and emits km/h (whole, hundredths+1) with a record address.
//
//   channel  dir  payload                                         handshake
//   in_ch    in   sensor_level                                    valid/ready
//   out_ch   out  speed_whole, speed_hundredths, store_address     valid/ready
//   cfg      in   cfg_index, cfg_wdata                            cfg_we
//
// A tick with no pulse only updates the count. A pulse runs the serial
// divider, 25 quotient bits at one per cycle, then the decimal split, the
// pending flag and the output register follow in that order; ticks are
// held off until the record is moved into the output register.
// A finished record waits in the output register; a new measurement can
// start while it waits, and completes once that register is free.
// Reset (synchronous) restores register defaults, zero count and address.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_period_speed_logger
  import wpsl_pkg::*;
#(
  parameter int STORE_BYTES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  wpsl_in_if.sink               in_ch,
  wpsl_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_BYTES);

  logic [CFG_W-1:0] circ;
  logic [CFG_W-1:0] lockout;
  logic [CNT_W-1:0] elapsed;
  logic [CNT_W-1:0] cnt_inc;
  logic [AW-1:0]    addr;
  logic [AW+1:0]    addr_step;
  logic [AW+9:0]    addr_ext;
  logic [9:0]       rec_addr;
  logic             meas;
  logic             pend;
  logic             out_valid;
  logic             acc;
  logic             trig;
  logic             start;
  logic             xfer;
  logic [DVD_W-1:0] dividend;
  logic             div_busy;
  qstream_t         qs;
  logic             dec_done;
  logic [7:0]       dec_whole;
  logic [6:0]       dec_hund;

  always_comb begin
    cnt_inc   = (elapsed == '1) ? elapsed : elapsed + CNT_W'(1);
    acc       = in_ch.valid && in_ch.ready;
    trig      = (cnt_inc > CNT_W'(lockout)) && in_ch.sensor_level;
    start     = acc && trig;
    xfer      = pend && (!out_valid || out_ch.ready);
    dividend  = DVD_W'(circ) * DVD_W'(CIRC_SCALE);
    addr_step = (AW+2)'(addr) + (AW+2)'(2);
    addr_ext  = (AW+10)'(addr);
  end

  wpsl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (dividend),
    .divisor  (cnt_inc),
    .busy     (div_busy),
    .qs       (qs)
  );

  wpsl_dec u_dec (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .qs               (qs),
    .done             (dec_done),
    .speed_whole      (dec_whole),
    .speed_hundredths (dec_hund)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      circ      <= CFG_W'(1350);
      lockout   <= CFG_W'(100);
      elapsed   <= '0;
      addr      <= '0;
      meas      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CIRC:    circ    <= cfg_wdata;
          REG_LOCKOUT: lockout <= cfg_wdata;
          default:     ;
        endcase
      end
      if (acc) begin
        if (trig) begin
          elapsed  <= '0;
          meas     <= 1'b1;
          rec_addr <= addr_ext[9:0];
          addr     <= ((addr_step + (AW+2)'(2)) > (AW+2)'(STORE_BYTES)) ?
                      '0 : addr_step[AW-1:0];
        end else begin
          elapsed <= cnt_inc;
        end
      end
      if (dec_done) begin
        pend <= 1'b1;
      end
      if (xfer) begin
        pend                    <= 1'b0;
        meas                    <= 1'b0;
        out_valid               <= 1'b1;
        out_ch.speed_whole      <= dec_whole;
        out_ch.speed_hundredths <= dec_hund;
        out_ch.store_address    <= rec_addr;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ch.ready  = !meas;
  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  a_div_in_meas: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> meas)
    else $error("divider running outside a measurement");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    dec_done |-> !pend)
    else $error("decimal result overwrote a pending one");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    start |=> (elapsed == '0))
    else $error("count not restarted after a pulse");

  a_hund_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.speed_hundredths != 7'd0 &&
                      out_ch.speed_hundredths <= 7'd100))
    else $error("hundredths out of range");
`endif

endmodule

`default_nettype wire

/* rtl/wpsl_div.sv */
// ----------------------------------------------------------------------------
// wpsl_div
// Restoring divider, one quotient bit per cycle, streamed out MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsl_div
  import wpsl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output qstream_t              qs
);

  logic             run;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0] dvd;
  logic [CNT_W-1:0] dsr;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_next;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    diff     = trial - {1'b0, dsr};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      qs.valid <= 1'b0;
    end else begin
      qs.valid <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (run) begin
        rem      <= rem_next;
        dvd      <= {dvd[DVD_W-2:0], 1'b0};
        step     <= step + STEP_W'(1);
        qs.valid <= 1'b1;
        qs.q     <= ge;
        qs.last  <= (step == STEP_W'(DVD_W - 1));
        if (step == STEP_W'(DVD_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign busy = run;

endmodule

`default_nettype wire

/* rtl/wpsl_dec.sv */
// ----------------------------------------------------------------------------
// wpsl_dec
// Bit-serial split of the quotient into hundreds and remainder mod 100.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsl_dec
  import wpsl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire qstream_t qs,
  output logic          done,
  output logic [7:0]    speed_whole,
  output logic [6:0]    speed_hundredths
);

  logic [6:0] rem;
  logic [7:0] quo;
  logic       ovf;
  logic [7:0] trial;
  logic       ge;
  logic [6:0] rem_next;

  always_comb begin
    trial    = {rem, qs.q};
    ge       = trial >= 8'(DEC_BASE);
    rem_next = ge ? 7'(trial - 8'(DEC_BASE)) : trial[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qs.valid && qs.last;
      if (start) begin
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
      end else if (qs.valid) begin
        rem <= rem_next;
        quo <= {quo[6:0], ge};
        ovf <= ovf | quo[7];
      end
    end
  end

  assign speed_whole      = ovf ? 8'hFF : quo;
  assign speed_hundredths = rem + 7'd1;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the wheel period speed logger. Millisecond ticks are fed
// through the tick channel. An in-bench speed predictor tracks the elapsed
// count, the lockout and the record address, and the speed records the block
// should produce are queued. Each record transaction is checked field by
// field. Both channels idle at random, and one long output hold-off stalls
// the block. Phases sweep the circumference and lockout, the circumference
// extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wpsl_pkg::*;

  localparam int STORE_BYTES   = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CFG_W-1:0] CIRC_RESET    = 16'd1350;
  localparam logic [CFG_W-1:0] LOCKOUT_RESET = 16'd100;

  typedef struct packed {
    logic [7:0] whole;
    logic [6:0] hund;
    logic [9:0] addr;
  } speed_rec_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  wpsl_in_if  in_ch ();
  wpsl_out_if out_ch ();

  wheel_period_speed_logger #(.STORE_BYTES(STORE_BYTES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [CFG_W-1:0] circ_mm;
  logic [CFG_W-1:0] lockout_ms;
  logic [CNT_W-1:0] ms_count;
  logic [9:0]       rec_addr;

  logic       tick_q[$];
  speed_rec_t speed_log_q[$];
  speed_rec_t exp_rec;
  logic       tick_taken;
  bit         idle_on;
  bit         hold_req;
  bit         hold_done;
  int         in_gap;
  int         out_gap;
  int         hold_left;
  int         errors;
  int         cycles;

  always #1 clk = ~clk;

  task automatic log_tick(input logic level);
    logic [63:0] quot;
    speed_rec_t  rec;
    if (ms_count != '1) ms_count = ms_count + 1'b1;
    if (ms_count > lockout_ms && level) begin
      quot = (64'(circ_mm) * CIRC_SCALE) / 64'(ms_count);
      rec.whole = (quot / DEC_BASE > 255) ? 8'hFF : 8'(quot / DEC_BASE);
      rec.hund  = 7'(quot % DEC_BASE + 1);
      rec.addr  = rec_addr;
      speed_log_q.push_back(rec);
      if (int'(rec_addr) + 4 > STORE_BYTES) rec_addr = '0;
      else rec_addr = rec_addr + 10'd2;
      ms_count = '0;
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_CIRC) circ_mm = val;
    else lockout_ms = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (tick_q.size() != 0 || speed_log_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] circ, input logic [CFG_W-1:0] lock,
                           input int n_ticks, input int high_pct);
    settle();
    write_reg(REG_CIRC, circ);
    write_reg(REG_LOCKOUT, lock);
    repeat (n_ticks) tick_q.push_back($urandom_range(0, 99) < high_pct);
  endtask

  // tick intake: predict on every accepted transaction
  always @(posedge clk) begin
    tick_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      log_tick(in_ch.sensor_level);
      tick_q.delete(0);
    end
  end

  // tick driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !tick_taken) begin
      // hold until accepted
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (tick_q.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(0, 3);
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid        <= 1'b1;
      in_ch.sensor_level <= tick_q[0];
    end
  end

  // record ready: random bursts plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // record monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (speed_log_q.size() == 0) begin
        $error("unexpected record: speed_whole %0d speed_hundredths %0d store_address %0d",
               out_ch.speed_whole, out_ch.speed_hundredths, out_ch.store_address);
        errors++;
      end else begin
        exp_rec = speed_log_q.pop_front();
        if (out_ch.speed_whole !== exp_rec.whole) begin
          $error("speed_whole: expected %0d, got %0d", exp_rec.whole, out_ch.speed_whole);
          errors++;
        end
        if (out_ch.speed_hundredths !== exp_rec.hund) begin
          $error("speed_hundredths: expected %0d, got %0d",
                 exp_rec.hund, out_ch.speed_hundredths);
          errors++;
        end
        if (out_ch.store_address !== exp_rec.addr) begin
          $error("store_address: expected %0d, got %0d", exp_rec.addr, out_ch.store_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_CIRC;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.sensor_level  = 1'b0;
    out_ch.ready        = 1'b0;
    tick_taken          = 1'b0;
    idle_on             = 1'b1;
    circ_mm             = CIRC_RESET;
    lockout_ms          = LOCKOUT_RESET;
    ms_count            = '0;
    rec_addr            = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // defaults: sensor high inside the lockout
    repeat (3) tick_q.push_back(1'b1);

    // largest wheel, no lockout: speed saturates
    settle();
    write_reg(REG_LOCKOUT, '0);
    write_reg(REG_CIRC, 16'hFFFF);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);

    // zero circumference
    settle();
    write_reg(REG_CIRC, '0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);

    // smallest wheel
    settle();
    write_reg(REG_CIRC, 16'd1);
    tick_q.push_back(1'b1);
    repeat (3) tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);

    // lockout edge; 83 mm over 23 ms gives hundredths at 100
    settle();
    write_reg(REG_CIRC, 16'd83);
    write_reg(REG_LOCKOUT, 16'd22);
    repeat (23) tick_q.push_back(1'b1);

    run_phase(CIRC_RESET, LOCKOUT_RESET, 150, 10);
    run_phase(16'd1, 16'd0, 200, 60);
    run_phase(16'hFFFF, 16'd0, 200, 60);
    repeat (2) run_phase(16'($urandom_range(1, 65535)), 16'd0, 200, 70);
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 20)), 200, 50);

    // output stall while ticks keep coming
    run_phase(16'($urandom), 16'd0, 150, 90);
    @(posedge clk);
    hold_req = 1'b1;

    // long lockout: restart the count, then cross the boundary
    settle();
    write_reg(REG_LOCKOUT, '0);
    tick_q.push_back(1'b1);
    run_phase(16'($urandom_range(1, 65535)), 16'd300, 300, 50);
    tick_q.push_back(1'b1);

    settle();
    idle_on = 1'b0;
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 3)), 200, 60);
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
